/* hw/rtl/gpw_pkg.sv */
// ----------------------------------------------------------------------------
// gpw_pkg: shared types and constants of the glyph pixel writer
// Field widths, register indexes, cursor limits and the 8x8 font table.
// ----------------------------------------------------------------------------
`default_nettype none

package gpw_pkg;

   // defaults of the top-level parameters
   localparam int FONT_CHARS_DEF = 256;
   localparam int ADDR_BITS_DEF  = 48;

   // glyph geometry
   localparam int GLYPH_ROWS   = 8;
   localparam int GLYPH_COLS   = 8;
   localparam int GLYPH_BITS   = GLYPH_ROWS * GLYPH_COLS;
   localparam int GLYPH_X_W    = $clog2(GLYPH_COLS);

   // field widths
   localparam int CODE_W       = 8;
   localparam int PIX_ADDR_W   = 48;
   localparam int COLOR_W      = 24;
   localparam int PITCH_W      = 16;
   localparam int SCR_WIDTH_W  = 14;
   localparam int COL_W        = 13;
   localparam int ROW_W        = 16;
   localparam int STRIDE_W     = PITCH_W - 2;
   // cursor_row * stride + cursor_col fits in this many bits
   localparam int IDX_W        = ROW_W + STRIDE_W + 1;
   localparam int MUL_CNT_W    = $clog2(STRIDE_W);

   // configuration port
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = PIX_ADDR_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_BASE  = 2'd0,
      CSR_LINE_PITCH  = 2'd1,
      CSR_SCR_WIDTH   = 2'd2,
      CSR_TEXT_COLOR  = 2'd3
   } csr_index_type;

   // register reset values
   localparam logic [PIX_ADDR_W-1:0]  FRAME_BASE_RST = '0;
   localparam logic [PITCH_W-1:0]     LINE_PITCH_RST = 16'd4096;
   localparam logic [SCR_WIDTH_W-1:0] SCR_WIDTH_RST  = 14'd1024;
   localparam logic [COLOR_W-1:0]     TEXT_COLOR_RST = 24'hFFFFFF;

   // cursor constants
   localparam logic [CODE_W-1:0]      NL_CODE   = 8'd10;
   localparam logic [ROW_W-1:0]       ROW_MAX   = 16'd65528;
   localparam logic [ROW_W-1:0]       ROW_STEP  = 16'd8;
   localparam logic [SCR_WIDTH_W-1:0] COL_STEP  = 14'd8;

   // font table, top row in the upper byte, leftmost pixel in the msb
   function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [CODE_W-1:0] code);
      logic [GLYPH_BITS-1:0] g;
      case (code)
         8'h41:   g = 64'h183C66667E666600;  // A
         8'h43:   g = 64'h3C66606060663C00;  // C
         8'h45:   g = 64'h7E60607C60607E00;  // E
         8'h49:   g = 64'h3C18181818183C00;  // I
         8'h4E:   g = 64'h66767E7E6E666600;  // N
         8'h4F:   g = 64'h3C66666666663C00;  // O
         8'h50:   g = 64'h7C66667C60606000;  // P
         8'h52:   g = 64'h7C66667C6C666600;  // R
         8'h53:   g = 64'h3C66603C06663C00;  // S
         8'h54:   g = 64'h7E18181818181800;  // T
         8'h56:   g = 64'hC3C3C3C3C3663C18;  // V
         8'h58:   g = 64'hC3C3663C183C66C3;  // X
         8'h59:   g = 64'h6666663C18181800;  // Y
         8'h2D:   g = 64'h0000007E00000000;  // dash
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/gpw_if.sv */
// ----------------------------------------------------------------------------
// gpw channel interfaces
// Valid/ready channels for character words, pixel write words and
// register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpw_req_if;
   import gpw_pkg::*;
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface gpw_rsp_if;
   import gpw_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [PIX_ADDR_W-1:0] pixel_addr;
   logic [COLOR_W-1:0]    pixel_value;
   logic                  last_pixel;

   modport source (output valid, output pixel_addr, output pixel_value,
                   output last_pixel, input ready);
   modport sink   (input valid, input pixel_addr, input pixel_value,
                   input last_pixel, output ready);
endinterface

interface gpw_csr_if;
   import gpw_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/gpw_mul_serial.sv */
// ----------------------------------------------------------------------------
// gpw_mul_serial: bit-serial multiply-add
// Computes mcand * mplier + addend one multiplier bit per cycle, lsb first,
// with a shift register on the multiplier and on the multiplicand.
// ----------------------------------------------------------------------------
`default_nettype none

module gpw_mul_serial (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [gpw_pkg::STRIDE_W-1:0] mplier,
   input  logic [gpw_pkg::ROW_W-1:0]    mcand,
   input  logic [gpw_pkg::COL_W-1:0]    addend,
   output logic                         done,
   output logic [gpw_pkg::IDX_W-1:0]    product
);
   import gpw_pkg::*;

   logic                 busy_ff,   busy_in;
   logic                 done_ff,   done_in;
   logic [MUL_CNT_W-1:0] cnt_ff,    cnt_in;
   logic [STRIDE_W-1:0]  mplier_ff, mplier_in;
   logic [IDX_W-1:0]     mcand_ff,  mcand_in;
   logic [IDX_W-1:0]     acc_ff,    acc_in;

   // one shift-add step per cycle
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mplier_in = mplier;
         mcand_in  = IDX_W'(mcand);
         acc_in    = IDX_W'(addend);
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mplier_in = mplier_ff >> 1;
         mcand_in  = mcand_ff << 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(STRIDE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operand shift registers and accumulator
   always_ff @(posedge clock) begin
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

/* hw/rtl/glyph_pixel_writer_core.sv */
// ----------------------------------------------------------------------------
// glyph_pixel_writer_core: 8x8 text renderer producing pixel write words
// Takes one character word at a time and emits one write word per set glyph
// bit, keeping a text cursor between characters.
// ----------------------------------------------------------------------------
// A newline, a glyph with no set bits, or any character while frame_base is
// zero leaves the block idle, and the next character is taken in the cycle after.
// A drawn character is held through S_MUL, a bit-serial multiply of the cursor
// row by the 14-bit pixel stride (one stride bit per cycle), then through S_SCAN,
// which scans the glyph bits in raster order up to the last set bit, at most 64;
// a set bit waits while the pixel channel holds ready low.
// A new character is taken as soon as the last write word is in the output
// register. Registers may only be written while no character is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_pixel_writer_core #(
   parameter int FONT_CHARS = gpw_pkg::FONT_CHARS_DEF,
   parameter int ADDR_BITS  = gpw_pkg::ADDR_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   gpw_req_if.sink   req_port,
   gpw_rsp_if.source rsp_port,
   gpw_csr_if.sink   csr_port
);
   import gpw_pkg::*;

   // address bits kept on the pixel channel
   localparam int ADDR_EFF = (ADDR_BITS < PIX_ADDR_W) ? ADDR_BITS : PIX_ADDR_W;
   localparam logic [PIX_ADDR_W-1:0] ADDR_MASK = (ADDR_EFF >= PIX_ADDR_W) ?
      {PIX_ADDR_W{1'b1}} : ((PIX_ADDR_W'(1) << ADDR_EFF) - PIX_ADDR_W'(1));

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_MUL  = 3'b010,
      S_SCAN = 3'b100
   } state_type;

   state_type               state_ff, state_in;

   // configuration registers
   logic [PIX_ADDR_W-1:0]   frame_base_ff;
   logic [PITCH_W-1:0]      line_pitch_ff;
   logic [SCR_WIDTH_W-1:0]  scr_width_ff;
   logic [COLOR_W-1:0]      text_color_ff;

   // cursor
   logic [COL_W-1:0]        cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0]        cursor_row_ff, cursor_row_in;

   // glyph scan
   logic [GLYPH_BITS-1:0]   glyph_ff,    glyph_in;
   logic [GLYPH_X_W-1:0]    gx_ff,       gx_in;
   logic [PIX_ADDR_W-1:0]   row_addr_ff, row_addr_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PIX_ADDR_W-1:0]   rsp_addr_ff,  rsp_addr_in;
   logic [COLOR_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff,  rsp_last_in;

   logic                    req_fire;
   logic                    csr_fire;
   logic                    is_newline;
   logic                    base_zero;
   logic                    code_blank;
   logic [GLYPH_BITS-1:0]   glyph_rom;
   logic                    draw_start;
   logic                    cursor_adv;
   logic                    row_adv;
   logic [STRIDE_W-1:0]     stride;
   logic                    slot_free;
   logic                    scan_bit;
   logic                    scan_rest_zero;
   logic                    scan_step;
   logic                    pix_load;
   logic                    glyph_done;
   logic [SCR_WIDTH_W-1:0]  next_col;
   logic                    col_wrap;
   logic [ROW_W-1:0]        row_sat;
   logic [PIX_ADDR_W-1:0]   pix_addr;
   logic                    mul_done;
   logic [IDX_W-1:0]        mul_prod;

   // handshakes
   assign req_fire         = req_port.valid && req_port.ready;
   assign csr_fire         = csr_port.valid && csr_port.ready;
   assign req_port.ready   = (state_ff == S_IDLE);
   assign csr_port.ready   = 1'b1;

   // character decode
   assign is_newline = (req_port.char_code == NL_CODE);
   assign base_zero  = (frame_base_ff == '0);
   assign code_blank = ({1'b0, req_port.char_code} >= (CODE_W + 1)'(FONT_CHARS));
   assign glyph_rom  = code_blank ? '0 : font_glyph(req_port.char_code);
   assign draw_start = req_fire && !base_zero && !is_newline && (glyph_rom != '0);
   assign row_adv    = req_fire && !base_zero && is_newline;

   // scan control, zero bits pass without needing the output slot
   assign stride         = line_pitch_ff[PITCH_W-1:2];
   assign slot_free      = !rsp_valid_ff || rsp_port.ready;
   assign scan_bit       = glyph_ff[GLYPH_BITS-1];
   assign scan_rest_zero = (glyph_ff[GLYPH_BITS-2:0] == '0);
   assign scan_step      = (state_ff == S_SCAN) && (!scan_bit || slot_free);
   assign pix_load       = scan_step && scan_bit;
   assign glyph_done     = pix_load && scan_rest_zero;
   assign cursor_adv     = glyph_done ||
                           (req_fire && !base_zero && !is_newline && (glyph_rom == '0));

   // pixel address within the current glyph row
   assign pix_addr = (row_addr_ff +
                      {{(PIX_ADDR_W - GLYPH_X_W - 2){1'b0}}, gx_ff, 2'b00}) & ADDR_MASK;

   // row start pixel index: cursor_row * stride + cursor_col, serially
   gpw_mul_serial u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (draw_start),
      .mplier  (stride),
      .mcand   (cursor_row_ff),
      .addend  (cursor_col_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   // sequencer and scan datapath
   always_comb begin
      state_in    = state_ff;
      glyph_in    = glyph_ff;
      gx_in       = gx_ff;
      row_addr_in = row_addr_ff;
      case (state_ff)
         S_IDLE: begin
            if (draw_start) begin
               state_in = S_MUL;
               glyph_in = glyph_rom;
               gx_in    = '0;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               state_in    = S_SCAN;
               row_addr_in = frame_base_ff +
                             {{(PIX_ADDR_W - IDX_W - 2){1'b0}}, mul_prod, 2'b00};
            end
         end
         S_SCAN: begin
            if (scan_step) begin
               glyph_in = glyph_ff << 1;
               gx_in    = gx_ff + 1'b1;
               if (gx_ff == GLYPH_X_W'(GLYPH_COLS - 1)) begin
                  row_addr_in = row_addr_ff +
                                {{(PIX_ADDR_W - STRIDE_W - 2){1'b0}}, stride, 2'b00};
               end
               if (glyph_done) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // cursor advance with wrap and row saturation
   always_comb begin
      next_col      = {1'b0, cursor_col_ff} + COL_STEP;
      col_wrap      = (next_col >= scr_width_ff) || next_col[SCR_WIDTH_W-1];
      row_sat       = (cursor_row_ff >= (ROW_MAX - ROW_STEP)) ? ROW_MAX
                                                              : cursor_row_ff + ROW_STEP;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      if (row_adv || (cursor_adv && col_wrap)) begin
         cursor_col_in = '0;
         cursor_row_in = row_sat;
      end else if (cursor_adv) begin
         cursor_col_in = next_col[COL_W-1:0];
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (pix_load) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = pix_addr;
         rsp_value_in = text_color_ff;
         rsp_last_in  = scan_rest_zero;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state, cursor and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         frame_base_ff <= FRAME_BASE_RST;
         line_pitch_ff <= LINE_PITCH_RST;
         scr_width_ff  <= SCR_WIDTH_RST;
         text_color_ff <= TEXT_COLOR_RST;
      end else begin
         state_ff      <= state_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_fire) begin
            case (csr_index_type'(csr_port.index))
               CSR_FRAME_BASE: frame_base_ff <= csr_port.data[PIX_ADDR_W-1:0];
               CSR_LINE_PITCH: line_pitch_ff <= csr_port.data[PITCH_W-1:0];
               CSR_SCR_WIDTH:  scr_width_ff  <= csr_port.data[SCR_WIDTH_W-1:0];
               CSR_TEXT_COLOR: text_color_ff <= csr_port.data[COLOR_W-1:0];
               default:        frame_base_ff <= frame_base_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      glyph_ff     <= glyph_in;
      gx_ff        <= gx_in;
      row_addr_ff  <= row_addr_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.pixel_addr  = rsp_addr_ff;
   assign rsp_port.pixel_value = rsp_value_ff;
   assign rsp_port.last_pixel  = rsp_last_ff;

   // cursor stays on the text grid and at or below the row limit
   a_cursor_grid: assert property (@(posedge clock) disable iff (reset)
      (cursor_col_ff[2:0] == 3'b000) && (cursor_row_ff[2:0] == 3'b000) &&
      (cursor_row_ff <= ROW_MAX))
      else $error("cursor off the text grid");

   // a glyph being scanned always has a set bit left
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (glyph_ff != '0))
      else $error("scan with no set bit left");

   // the multiplier finishes only while the sequencer waits for it
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_MUL))
      else $error("multiply finished outside its wait state");

   // the final pixel of a glyph is presented flagged and the block goes idle
   a_last_pixel: assert property (@(posedge clock) disable iff (reset)
      glyph_done |=> (state_ff == S_IDLE) && rsp_valid_ff && rsp_last_ff)
      else $error("final pixel not flagged or block not idle");

endmodule

`default_nettype wire
